/* hw/rtl/rbe_pkg.sv */
// Shared types and constants for the rank bit-page encoder.
// No dependencies.
package rbe_pkg;

   localparam int MAX_PAGES_DEF = 32;
   localparam int QDEPTH        = 4;
   localparam int TOTAL_W       = 40;

   localparam logic [1:0] KIND_RANK  = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   localparam logic [1:0] RK_FULL = 2'd0;
   localparam logic [1:0] RK_TAIL = 2'd1;
   localparam logic [1:0] RK_ERR  = 2'd2;

   typedef enum logic [1:0] {
      OP_DATA  = 2'd0,
      OP_ERR   = 2'd1,
      OP_FLUSH = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] rank;
      logic [5:0] upto;
   } cmd_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [3:0]         vbits;
      logic [7:0]         pbyte;
      logic [5:0]         page;
      logic [1:0]         kind;
   } res_type;

endpackage

/* hw/rtl/rbe_front.sv */
// Front end: accepts input transfers, keeps the rank table, classifies items.
// Depends on rbe_pkg.
module rbe_front #(
   parameter int MAX_PAGES = rbe_pkg::MAX_PAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [6:0]       page_count,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // symbol[7:0], rank[14:8], present[15]
   input  logic [1:0]       req_tuser,   // kind
   input  logic             q_ready,
   output logic             q_push,
   output rbe_pkg::cmd_type q_cmd
);

   logic [6:0] rmem [256];
   logic [255:0] rvalid_ff;
   logic       f_valid_ff, f_valid_in;
   logic       f_flush_ff;
   logic [6:0] rank_ff;
   logic       rv_ff;
   logic       accept;
   logic [7:0] sym;
   logic [6:0] np, npm1;

   assign sym        = req_tdata[7:0];
   assign q_push     = f_valid_ff && q_ready;
   assign req_tready = !f_valid_ff || q_push;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (page_count == 7'd0) np = 7'd1;
      else if (page_count > 7'(MAX_PAGES)) np = 7'(MAX_PAGES);
      else np = page_count;
      npm1 = np - 7'd1;
   end

   always_comb begin
      q_cmd.rank = rank_ff;
      if (f_flush_ff) begin
         q_cmd.op   = rbe_pkg::OP_FLUSH;
         q_cmd.upto = npm1[5:0];
      end else if (rv_ff) begin
         q_cmd.op   = rbe_pkg::OP_DATA;
         q_cmd.upto = (rank_ff < npm1) ? rank_ff[5:0] : npm1[5:0];
      end else begin
         q_cmd.op   = rbe_pkg::OP_ERR;
         q_cmd.upto = 6'd0;
      end
   end

   always_comb begin
      if (accept)
         f_valid_in = (req_tuser == rbe_pkg::KIND_DATA) || (req_tuser == rbe_pkg::KIND_FLUSH);
      else if (q_push)
         f_valid_in = 1'b0;
      else
         f_valid_in = f_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         rvalid_ff  <= '0;
      end else begin
         f_valid_ff <= f_valid_in;
         if (accept && req_tuser == rbe_pkg::KIND_RANK)
            rvalid_ff[sym] <= req_tdata[15];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_flush_ff <= (req_tuser == rbe_pkg::KIND_FLUSH);
         if (req_tuser == rbe_pkg::KIND_DATA) begin
            rank_ff <= rmem[sym];
            rv_ff   <= rvalid_ff[sym];
         end
         if (req_tuser == rbe_pkg::KIND_RANK)
            rmem[sym] <= req_tdata[14:8];
      end
   end

endmodule

/* hw/rtl/rbe_cmd_fifo.sv */
// Short command queue between front and back ends.
// Depends on rbe_pkg.
module rbe_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbe_pkg::cmd_type push_cmd,
   output logic             not_full,
   input  logic             pop,
   output logic             not_empty,
   output rbe_pkg::cmd_type pop_cmd
);

   localparam int AW = $clog2(rbe_pkg::QDEPTH);

   rbe_pkg::cmd_type slot_ff [rbe_pkg::QDEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff, cnt_in;

   assign not_full  = cnt_ff != (AW+1)'(rbe_pkg::QDEPTH);
   assign not_empty = cnt_ff != '0;
   assign pop_cmd   = slot_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_cmd;
   end

endmodule

/* hw/rtl/rbe_back.sv */
// Back end: walks pages for each command, updates page memory, emits results.
// Depends on rbe_pkg.
module rbe_back #(
   parameter int MAX_PAGES = rbe_pkg::MAX_PAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  rbe_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata,   // page[5:0], packed_byte[13:6], valid_bits[17:14],
                                         // page_bit_total[57:18]
   output logic [1:0]       rsp_tuser,   // result_kind
   output logic             rsp_tlast
);

   localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int TW = rbe_pkg::TOTAL_W;
   localparam int WW = TW + 11;

   logic [WW-1:0] pmem [MAX_PAGES];
   logic [MAX_PAGES-1:0] pvld_ff;

   logic              a_busy_ff;
   rbe_pkg::op_type   a_op_ff;
   logic [6:0]        a_rank_ff;
   logic [PW-1:0]     a_upto_ff, a_pg_ff;

   logic              b_valid_ff;
   rbe_pkg::op_type   b_op_ff;
   logic [6:0]        b_rank_ff;
   logic [PW-1:0]     b_page_ff;
   logic              b_last_ff;
   logic [WW-1:0]     rd_ff, byp_ff;
   logic              haz_ff;

   logic              pend_v_ff, pend_v_in, pend_fin_ff, pend_fin_in;
   rbe_pkg::res_type  pend_ff, pend_in;
   logic              rsp_v_ff, rsp_v_in, rsp_last_ff;
   rbe_pkg::res_type  rsp_ff;

   logic [WW-1:0]     word, wr_data;
   logic [7:0]        accum, acc_new;
   logic [2:0]        fill;
   logic [TW-1:0]     cnt;
   logic              full, b_res, out_free, move, b_fire, adv, wr_en;
   rbe_pkg::res_type  res;

   assign cmd_pop = cmd_valid && !a_busy_ff;

   always_comb begin
      word    = pvld_ff[b_page_ff] ? (haz_ff ? byp_ff : rd_ff) : '0;
      accum   = word[7:0];
      fill    = word[10:8];
      cnt     = word[WW-1:11];
      acc_new = accum | ((7'(b_page_ff) == b_rank_ff) ? (8'h80 >> fill) : 8'h00);
      full    = fill == 3'd7;
      wr_data = {cnt + TW'(1), full ? 3'd0 : fill + 3'd1, full ? 8'h00 : acc_new};
      res     = '0;
      unique case (b_op_ff)
         rbe_pkg::OP_DATA: begin
            res.kind  = rbe_pkg::RK_FULL;
            res.page  = 6'(b_page_ff);
            res.pbyte = acc_new;
            res.vbits = 4'd8;
         end
         rbe_pkg::OP_FLUSH: begin
            res.kind  = rbe_pkg::RK_TAIL;
            res.page  = 6'(b_page_ff);
            res.pbyte = accum;
            res.vbits = {1'b0, fill};
            res.total = cnt;
         end
         default: res.kind = rbe_pkg::RK_ERR;
      endcase
   end

   assign b_res    = b_valid_ff && (b_op_ff != rbe_pkg::OP_DATA || full);
   assign out_free = !rsp_v_ff || rsp_tready;
   assign move     = pend_v_ff && out_free && (pend_fin_ff || b_res);
   assign b_fire   = b_valid_ff && !(b_res && pend_v_ff && !move);
   assign adv      = !b_valid_ff || b_fire;
   assign wr_en    = b_fire && b_op_ff == rbe_pkg::OP_DATA;

   always_comb begin
      pend_v_in   = pend_v_ff;
      pend_fin_in = pend_fin_ff;
      pend_in     = pend_ff;
      if (b_fire && b_res) begin
         pend_v_in   = 1'b1;
         pend_fin_in = b_last_ff;
         pend_in     = res;
      end else if (move) begin
         pend_v_in = 1'b0;
      end else if (b_fire && b_last_ff) begin
         pend_fin_in = 1'b1;
      end
      if (move) rsp_v_in = 1'b1;
      else if (rsp_tready) rsp_v_in = 1'b0;
      else rsp_v_in = rsp_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_busy_ff   <= 1'b0;
         b_valid_ff  <= 1'b0;
         pend_v_ff   <= 1'b0;
         pend_fin_ff <= 1'b0;
         rsp_v_ff    <= 1'b0;
         pvld_ff     <= '0;
      end else begin
         pend_v_ff   <= pend_v_in;
         pend_fin_ff <= pend_fin_in;
         rsp_v_ff    <= rsp_v_in;
         if (adv) b_valid_ff <= a_busy_ff;
         if (cmd_pop) a_busy_ff <= 1'b1;
         else if (adv && a_busy_ff && a_pg_ff == a_upto_ff) a_busy_ff <= 1'b0;
         if (wr_en) pvld_ff[b_page_ff] <= 1'b1;
         else if (b_fire && b_op_ff == rbe_pkg::OP_FLUSH && b_last_ff) pvld_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (move) begin
         rsp_ff      <= pend_ff;
         rsp_last_ff <= pend_fin_ff;
      end
      if (cmd_pop) begin
         a_op_ff   <= cmd.op;
         a_rank_ff <= cmd.rank;
         a_upto_ff <= cmd.upto[PW-1:0];
         a_pg_ff   <= '0;
      end else if (adv && a_busy_ff) begin
         a_pg_ff <= a_pg_ff + 1'b1;
      end
      if (adv) begin
         b_op_ff   <= a_op_ff;
         b_rank_ff <= a_rank_ff;
         b_page_ff <= a_pg_ff;
         b_last_ff <= a_pg_ff == a_upto_ff;
         rd_ff     <= pmem[a_pg_ff];
         haz_ff    <= wr_en && b_page_ff == a_pg_ff;
         byp_ff    <= wr_data;
      end
      if (wr_en) pmem[b_page_ff] <= wr_data;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.total, rsp_ff.vbits, rsp_ff.pbyte, rsp_ff.page};

`ifndef SYNTHESIS
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_op_ff == rbe_pkg::OP_ERR |-> b_last_ff)
      else $error("error command spans more than one page");
   a_pend_replace: assert property (@(posedge clock) disable iff (reset)
      move && !pend_fin_ff |-> b_valid_ff && b_res)
      else $error("non-final result left without replacement");
   a_b_hold: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_fire |=> b_valid_ff && $stable(b_page_ff))
      else $error("stalled page step changed");
`endif

endmodule

/* hw/rtl/rank_bitpage_encoder_unit.sv */
// Top level of the rank bit-page encoder: config register, front, queue, back.
// Depends on rbe_pkg, rbe_front, rbe_cmd_fifo, rbe_back.
// The back end walks one page memory step per cycle, unless the output stalls: a data
// byte of rank r visits pages 0 to min(r, pages-1), a flush visits every page, and
// a new command loads once the last one has issued its last page.
// Reset: synchronous; clears rank and page valid bits, page_count returns to 1.
module rank_bitpage_encoder_unit #(
   parameter int MAX_PAGES = rbe_pkg::MAX_PAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // symbol[7:0], rank[14:8], present[15]
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // page[5:0], packed_byte[13:6], valid_bits[17:14],
                                    // page_bit_total[57:18]
   output logic [1:0]  rsp_tuser,   // result_kind
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [6:0] page_count_ff;
   logic       q_push, q_ready, q_nempty, q_pop;
   rbe_pkg::cmd_type push_cmd, pop_cmd;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 1'b0) ? {25'd0, page_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) page_count_ff <= 7'd1;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0)
         page_count_ff <= csr_pwdata[6:0];
   end

   rbe_front #(.MAX_PAGES(MAX_PAGES)) u_front (
      .clock(clock), .reset(reset), .page_count(page_count_ff),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .q_ready(q_ready), .q_push(q_push), .q_cmd(push_cmd)
   );

   rbe_cmd_fifo u_fifo (
      .clock(clock), .reset(reset), .push(q_push), .push_cmd(push_cmd),
      .not_full(q_ready), .pop(q_pop), .not_empty(q_nempty), .pop_cmd(pop_cmd)
   );

   rbe_back #(.MAX_PAGES(MAX_PAGES)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(q_nempty), .cmd(pop_cmd),
      .cmd_pop(q_pop), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

endmodule
